@@ design/tltw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tltw_pkg
// Sizes and codes shared by the two-level timer wheel.
// ----------------------------------------------------------------------------
package tltw_pkg;

    localparam int BUCKETS = 64;               // buckets per level, power of two
    localparam int TIMERS  = 32;               // timer slots
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int ID_W    = $clog2(TIMERS);
    localparam int LNK_W   = ID_W + 1;         // slot number or NIL
    localparam int LIST_W  = BKT_W + 1;        // level bit + bucket
    localparam int NBKT    = 2 * BUCKETS;
    localparam int TICK_W  = 64;
    localparam int PER_W   = 32;
    localparam int TAG_W   = 32;

    localparam logic [LNK_W-1:0] NIL = '1;

    localparam logic [1:0] CMD_ONESHOT  = 2'd0;
    localparam logic [1:0] CMD_PERIODIC = 2'd1;
    localparam logic [1:0] CMD_CANCEL   = 2'd2;
    localparam logic [1:0] CMD_TICK     = 2'd3;

    localparam logic [2:0] K_CREATED   = 3'd0;
    localparam logic [2:0] K_FIRED     = 3'd1;
    localparam logic [2:0] K_REFUSED   = 3'd2;
    localparam logic [2:0] K_CANCELLED = 3'd3;
    localparam logic [2:0] K_FREE      = 3'd4;
    localparam logic [2:0] K_TICK_DONE = 3'd5;

endpackage : tltw_pkg
`default_nettype wire

@@ design/two_level_timer_wheel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_timer_wheel
// Two-level timing wheel with a slot pool, run by a small sequencer.
// ----------------------------------------------------------------------------
// Each command runs to completion through the sequencer states; a stalled
//   result holds the sequencer in S_EMIT until the output register is free.
// Throughput: one command at a time; in_ready returns in the same cycle that
//   the last result is presented. Reset: async; counter, cursors zero, buckets
//   empty via valid bits.
module two_level_timer_wheel (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  cmd,
    input  wire logic [tltw_pkg::TICK_W-1:0] deadline_tick,
    input  wire logic [tltw_pkg::TICK_W-1:0] start_delay,
    input  wire logic [tltw_pkg::PER_W-1:0]  period,
    input  wire logic [tltw_pkg::ID_W-1:0]   handle,
    input  wire logic [tltw_pkg::TAG_W-1:0]  user_tag,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [2:0]                       kind,
    output logic [tltw_pkg::ID_W-1:0]        timer_id,
    output logic [tltw_pkg::TAG_W-1:0]       fired_tag,
    output logic [tltw_pkg::TICK_W-1:0]      now_tick,
    output logic                             last
);
    import tltw_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_EMIT, S_CR, S_TK_RD, S_TK_DET, S_LOOP0, S_CS_RD, S_CS_DET,
        S_LOOPC, S_FIRE, S_FIRE_TAIL, S_PL_REM, S_PL_DEC, S_PB_RD, S_PB_W1,
        S_PB_W2, S_ROUTE, S_CN_A, S_CN_B, S_CN_C
    } state_t;

    // what the sequencer returns to after a list insert
    typedef enum logic [1:0] {CX_CREATE, CX_TICK0, CX_CASC, CX_CANCEL} ctx_t;

    state_t state_reg, ret_reg;
    ctx_t   ctx_reg;

    // control and architectural state
    logic [TICK_W-1:0] tick_reg;
    logic [BKT_W-1:0]  low_reg, high_reg;
    logic [LNK_W-1:0]  free_head_reg, free_tail_reg;
    logic [LNK_W-1:0]  link_next_reg [TIMERS];
    logic [LNK_W-1:0]  link_prev_reg [TIMERS];
    logic [TIMERS-1:0] active_reg;
    logic [NBKT-1:0]   bkt_vld_reg;

    // working registers
    logic [LNK_W-1:0]  e_reg, nx_reg, p_reg, tail_reg;
    logic [LIST_W-1:0] list_reg;
    logic              to_free_reg, rearm_reg;
    logic [TICK_W-1:0] rem_reg, arg_dl_reg;
    logic [PER_W-1:0]  per_in_reg;
    logic [TAG_W-1:0]  tag_in_reg, tag_keep_reg;
    logic [1:0]        cmd_reg;
    logic [2:0]        em_kind_reg;
    logic [ID_W-1:0]   em_id_reg;
    logic [TAG_W-1:0]  em_tag_reg;
    logic              em_last_reg;

    // output register
    logic              out_valid_reg, last_reg;
    logic [2:0]        kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TAG_W-1:0]  ftag_reg;
    logic [TICK_W-1:0] now_reg;

    // per-slot payload, no reset
    logic [TICK_W-1:0] slot_dl   [TIMERS];
    logic [PER_W-1:0]  slot_per  [TIMERS];
    logic [TAG_W-1:0]  slot_tag  [TIMERS];
    logic [LIST_W-1:0] slot_place[TIMERS];

    // bucket ends memory: {head, tail}
    logic [2*LNK_W-1:0] bkt_mem [NBKT];
    logic [2*LNK_W-1:0] mem_q;
    logic               vld_q;
    logic               mem_we;
    logic [LIST_W-1:0]  mem_wa, mem_ra;
    logic [2*LNK_W-1:0] mem_wd;

    logic [ID_W-1:0]   e_idx;
    logic [LNK_W-1:0]  cur_next, cur_prev, bkt_head_q, bkt_tail_q, push_tail;
    logic [TICK_W-1:0] cur_dl;
    logic [PER_W-1:0]  cur_per;
    logic [TAG_W-1:0]  cur_tag;
    logic [LIST_W-1:0] cur_place;
    logic              dl_we, per_we, tag_we, place_we;
    logic [TICK_W-1:0] dl_wd;
    logic [PER_W-1:0]  per_wd;
    logic              handle_ok, casc;
    logic [BKT_W-1:0]  delta0;

    assign e_idx     = e_reg[ID_W-1:0];
    assign cur_next  = link_next_reg[e_idx];
    assign cur_prev  = link_prev_reg[e_idx];
    assign cur_dl    = slot_dl[e_idx];
    assign cur_per   = slot_per[e_idx];
    assign cur_tag   = slot_tag[e_idx];
    assign cur_place = slot_place[e_idx];

    // an unwritten bucket reads as empty
    assign bkt_head_q = vld_q ? mem_q[2*LNK_W-1:LNK_W] : NIL;
    assign bkt_tail_q = vld_q ? mem_q[LNK_W-1:0] : NIL;
    assign push_tail  = to_free_reg ? free_tail_reg : bkt_tail_q;

    assign handle_ok = (LNK_W'(handle) < LNK_W'(TIMERS)) && active_reg[handle];
    assign casc      = !rearm_reg && (ctx_reg == CX_CASC);
    assign delta0    = (rem_reg[BKT_W-1:0] == '0) ? BKT_W'(1) : rem_reg[BKT_W-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign timer_id  = id_reg;
    assign fired_tag = ftag_reg;
    assign now_tick  = now_reg;
    assign last      = last_reg;

    // bucket memory port control
    always_comb
    begin
        mem_ra = list_reg;
        mem_we = 1'b0;
        mem_wa = list_reg;
        mem_wd = {NIL, NIL};
        unique case (state_reg)
            S_TK_RD:  mem_ra = {1'b0, low_reg};
            S_CS_RD:  mem_ra = {1'b1, high_reg};
            S_CN_A:   mem_ra = cur_place;
            S_TK_DET:
            begin
                mem_we = 1'b1;
                mem_wa = {1'b0, low_reg};
            end
            S_CS_DET:
            begin
                mem_we = 1'b1;
                mem_wa = {1'b1, high_reg};
            end
            S_PB_W1:
            begin
                mem_we = !to_free_reg;
                mem_wd = {(push_tail == NIL) ? e_reg : bkt_head_q, e_reg};
            end
            S_CN_B:
            begin
                mem_we = 1'b1;
                mem_wd = {(p_reg == NIL) ? nx_reg : bkt_head_q,
                          (nx_reg == NIL) ? p_reg : bkt_tail_q};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bkt_mem[mem_wa] <= mem_wd;
        end
        mem_q <= bkt_mem[mem_ra];
    end

    // slot payload writes
    always_comb
    begin
        dl_we    = 1'b0;
        per_we   = 1'b0;
        tag_we   = 1'b0;
        place_we = 1'b0;
        dl_wd    = arg_dl_reg;
        per_wd   = (cmd_reg == CMD_ONESHOT) ? '0 : per_in_reg;
        unique case (state_reg)
            S_CR:
            begin
                dl_we  = 1'b1;
                per_we = 1'b1;
                tag_we = 1'b1;
            end
            S_FIRE_TAIL:
            begin
                dl_we = (cur_per != '0);
                dl_wd = tick_reg + TICK_W'(cur_per);
            end
            S_PB_W1:  place_we = !to_free_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            slot_dl[e_idx] <= dl_wd;
        end
        if (per_we)
        begin
            slot_per[e_idx] <= per_wd;
        end
        if (tag_we)
        begin
            slot_tag[e_idx] <= tag_in_reg;
        end
        if (place_we)
        begin
            slot_place[e_idx] <= list_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            ctx_reg       <= CX_CREATE;
            tick_reg      <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            free_head_reg <= '0;
            free_tail_reg <= LNK_W'(TIMERS - 1);
            for (int i = 0; i < TIMERS; i++)
            begin
                link_next_reg[i] <= (i == TIMERS - 1) ? NIL : LNK_W'(i + 1);
                link_prev_reg[i] <= (i == 0) ? NIL : LNK_W'(i - 1);
            end
            active_reg    <= '0;
            bkt_vld_reg   <= '0;
            vld_q         <= 1'b0;
            out_valid_reg <= 1'b0;
            rearm_reg     <= 1'b0;
            to_free_reg   <= 1'b0;
        end
        else
        begin
            vld_q <= bkt_vld_reg[mem_ra];
            if (mem_we)
            begin
                bkt_vld_reg[mem_wa] <= 1'b1;
            end
            // S_EMIT drives the valid flag itself
            if (out_valid_reg && out_ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg    <= cmd;
                        per_in_reg <= period;
                        tag_in_reg <= user_tag;
                        arg_dl_reg <= (cmd == CMD_ONESHOT) ? deadline_tick
                                                           : tick_reg + start_delay;
                        if (cmd == CMD_TICK)
                        begin
                            tick_reg  <= tick_reg + 1'b1;
                            state_reg <= S_TK_RD;
                        end
                        else if (cmd == CMD_CANCEL)
                        begin
                            if (handle_ok)
                            begin
                                e_reg     <= LNK_W'(handle);
                                ctx_reg   <= CX_CANCEL;
                                state_reg <= S_CN_A;
                            end
                            else
                            begin
                                em_kind_reg <= K_FREE;
                                em_id_reg   <= handle;
                                em_tag_reg  <= '0;
                                em_last_reg <= 1'b1;
                                ret_reg     <= S_IDLE;
                                state_reg   <= S_EMIT;
                            end
                        end
                        else if (free_head_reg >= LNK_W'(TIMERS) ||
                                 (cmd == CMD_PERIODIC && period == '0))
                        begin
                            em_kind_reg <= K_REFUSED;
                            em_id_reg   <= '0;
                            em_tag_reg  <= user_tag;
                            em_last_reg <= 1'b1;
                            ret_reg     <= S_IDLE;
                            state_reg   <= S_EMIT;
                        end
                        else
                        begin
                            e_reg     <= free_head_reg;
                            ctx_reg   <= CX_CREATE;
                            state_reg <= S_CR;
                        end
                    end
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= em_kind_reg;
                        id_reg        <= em_id_reg;
                        ftag_reg      <= em_tag_reg;
                        now_reg       <= tick_reg;
                        last_reg      <= em_last_reg;
                        state_reg     <= ret_reg;
                    end
                end

                S_CR:
                begin
                    free_head_reg <= cur_next;
                    if (cur_next == NIL)
                    begin
                        free_tail_reg <= NIL;
                    end
                    else
                    begin
                        link_prev_reg[cur_next[ID_W-1:0]] <= NIL;
                    end
                    active_reg[e_idx] <= 1'b1;
                    rearm_reg         <= 1'b0;
                    state_reg         <= S_PL_REM;
                end

                S_PL_REM:
                begin
                    rem_reg   <= (cur_dl > tick_reg) ? cur_dl - tick_reg : '0;
                    state_reg <= S_PL_DEC;
                end

                S_PL_DEC:
                begin
                    to_free_reg <= 1'b0;
                    if (casc && rem_reg == '0)
                    begin
                        state_reg <= S_FIRE;
                    end
                    else if (rem_reg[TICK_W-1:BKT_W] == '0)
                    begin
                        list_reg  <= {1'b0, low_reg + delta0};
                        state_reg <= S_PB_RD;
                    end
                    else if (rem_reg[TICK_W-1:2*BKT_W] == '0)
                    begin
                        list_reg  <= {1'b1, high_reg + rem_reg[2*BKT_W-1:BKT_W] - 1'b1};
                        state_reg <= S_PB_RD;
                    end
                    else if (rearm_reg || casc)
                    begin
                        // beyond level 1: farthest level-1 bucket
                        list_reg  <= {1'b1, high_reg + {BKT_W{1'b1}}};
                        state_reg <= S_PB_RD;
                    end
                    else
                    begin
                        state_reg <= S_FIRE;
                    end
                end

                S_FIRE:
                begin
                    em_kind_reg <= K_FIRED;
                    em_id_reg   <= e_idx;
                    em_tag_reg  <= cur_tag;
                    em_last_reg <= 1'b0;
                    ret_reg     <= S_FIRE_TAIL;
                    state_reg   <= S_EMIT;
                end

                S_FIRE_TAIL:
                begin
                    if (cur_per != '0)
                    begin
                        rearm_reg <= 1'b1;
                        state_reg <= S_PL_REM;
                    end
                    else
                    begin
                        active_reg[e_idx] <= 1'b0;
                        to_free_reg       <= 1'b1;
                        state_reg         <= S_PB_RD;
                    end
                end

                S_PB_RD:  state_reg <= S_PB_W1;

                S_PB_W1:
                begin
                    link_prev_reg[e_idx] <= push_tail;
                    link_next_reg[e_idx] <= NIL;
                    if (to_free_reg)
                    begin
                        if (push_tail == NIL)
                        begin
                            free_head_reg <= e_reg;
                        end
                        free_tail_reg <= e_reg;
                    end
                    tail_reg  <= push_tail;
                    state_reg <= (push_tail == NIL) ? S_ROUTE : S_PB_W2;
                end

                S_PB_W2:
                begin
                    link_next_reg[tail_reg[ID_W-1:0]] <= e_reg;
                    state_reg <= S_ROUTE;
                end

                S_ROUTE:
                begin
                    unique case (ctx_reg)
                        CX_TICK0:
                        begin
                            e_reg     <= nx_reg;
                            state_reg <= S_LOOP0;
                        end
                        CX_CASC:
                        begin
                            e_reg     <= nx_reg;
                            state_reg <= S_LOOPC;
                        end
                        CX_CREATE:
                        begin
                            em_kind_reg <= K_CREATED;
                            em_id_reg   <= e_idx;
                            em_tag_reg  <= tag_in_reg;
                            em_last_reg <= 1'b1;
                            ret_reg     <= S_IDLE;
                            state_reg   <= S_EMIT;
                        end
                        default:
                        begin
                            em_kind_reg <= K_CANCELLED;
                            em_id_reg   <= e_idx;
                            em_tag_reg  <= tag_keep_reg;
                            em_last_reg <= 1'b1;
                            ret_reg     <= S_IDLE;
                            state_reg   <= S_EMIT;
                        end
                    endcase
                end

                S_TK_RD:  state_reg <= S_TK_DET;

                S_TK_DET:
                begin
                    e_reg     <= bkt_head_q;
                    ctx_reg   <= CX_TICK0;
                    state_reg <= S_LOOP0;
                end

                S_LOOP0:
                begin
                    if (e_reg >= LNK_W'(TIMERS))
                    begin
                        low_reg <= low_reg + 1'b1;
                        if (low_reg == BKT_W'(BUCKETS - 1))
                        begin
                            state_reg <= S_CS_RD;
                        end
                        else
                        begin
                            em_kind_reg <= K_TICK_DONE;
                            em_id_reg   <= '0;
                            em_tag_reg  <= '0;
                            em_last_reg <= 1'b1;
                            ret_reg     <= S_IDLE;
                            state_reg   <= S_EMIT;
                        end
                    end
                    else
                    begin
                        nx_reg    <= cur_next;
                        state_reg <= S_FIRE;
                    end
                end

                S_CS_RD:  state_reg <= S_CS_DET;

                S_CS_DET:
                begin
                    e_reg     <= bkt_head_q;
                    high_reg  <= high_reg + 1'b1;
                    ctx_reg   <= CX_CASC;
                    state_reg <= S_LOOPC;
                end

                S_LOOPC:
                begin
                    if (e_reg >= LNK_W'(TIMERS))
                    begin
                        em_kind_reg <= K_TICK_DONE;
                        em_id_reg   <= '0;
                        em_tag_reg  <= '0;
                        em_last_reg <= 1'b1;
                        ret_reg     <= S_IDLE;
                        state_reg   <= S_EMIT;
                    end
                    else
                    begin
                        nx_reg    <= cur_next;
                        rearm_reg <= 1'b0;
                        state_reg <= S_PL_REM;
                    end
                end

                S_CN_A:
                begin
                    tag_keep_reg <= cur_tag;
                    list_reg     <= cur_place;
                    p_reg        <= cur_prev;
                    nx_reg       <= cur_next;
                    state_reg    <= S_CN_B;
                end

                S_CN_B:
                begin
                    if (p_reg != NIL)
                    begin
                        link_next_reg[p_reg[ID_W-1:0]] <= nx_reg;
                    end
                    state_reg <= S_CN_C;
                end

                S_CN_C:
                begin
                    if (nx_reg != NIL)
                    begin
                        link_prev_reg[nx_reg[ID_W-1:0]] <= p_reg;
                    end
                    active_reg[e_idx] <= 1'b0;
                    to_free_reg       <= 1'b1;
                    state_reg         <= S_PB_RD;
                end

                default:  state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_free_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg == NIL) == (free_tail_reg == NIL))
        else $error("free list ends disagree");

    a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("command produced no work");

    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == K_FIRED) |-> !last)
        else $error("fire result marked last");

    a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PB_W1) |-> (e_reg < LNK_W'(TIMERS)))
        else $error("insert of invalid slot");
`endif

endmodule : two_level_timer_wheel
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level timer wheel: queued commands are
// driven with random gaps, every result transfer is compared in order against
// an in-bench model of the wheel, and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
    import tltw_pkg::*;

    localparam int WATCHDOG  = 20000;   // cycles with no transfer on either side
    localparam int LIST_NIL  = 63;
    localparam int FREE_LIST = 2 * BUCKETS;
    localparam int FAR       = BUCKETS * BUCKETS;

    typedef struct {
        logic [1:0]  cmd;
        logic [63:0] dl;
        logic [63:0] sd;
        logic [31:0] per;
        logic [4:0]  hnd;
        logic [31:0] tag;
    } cmd_item_t;

    typedef struct {
        logic [2:0]  kind;
        logic [4:0]  id;
        logic [31:0] tag;
        logic [63:0] now;
        logic        last;
    } wheel_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [63:0] deadline_tick;
    logic [63:0] start_delay;
    logic [31:0] period;
    logic [4:0]  handle;
    logic [31:0] user_tag;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [4:0]  timer_id;
    logic [31:0] fired_tag;
    logic [63:0] now_tick;
    logic        last;

    two_level_timer_wheel dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .deadline_tick(deadline_tick), .start_delay(start_delay),
        .period(period), .handle(handle), .user_tag(user_tag),
        .out_valid(out_valid), .out_ready(out_ready),
        .kind(kind), .timer_id(timer_id), .fired_tag(fired_tag),
        .now_tick(now_tick), .last(last)
    );

    // ------------------------------------------------------------------
    // Wheel model state
    // ------------------------------------------------------------------
    logic [63:0] w_now;
    int          w_lcur;
    int          w_hcur;
    logic [63:0] w_deadline [TIMERS];
    logic [31:0] w_period   [TIMERS];
    logic [31:0] w_tag      [TIMERS];
    int          w_place    [TIMERS];
    int          w_next     [TIMERS];
    int          w_prev     [TIMERS];
    bit          w_active   [TIMERS];
    int          w_head     [2*BUCKETS+1];
    int          w_tail     [2*BUCKETS+1];

    wheel_result_t expected_q[$];
    cmd_item_t     cmd_q[$];

    int  fails;
    int  sent_cnt;
    int  acc_cnt;
    int  res_cnt;
    int  rx_seen;
    int  gap;
    bit  quiet;
    int  rx_wait;
    int  hold_cnt;
    bit  hold_req;
    bit  hold_done;
    int  idle_cycles;
    logic [63:0] sched_now;   // tick count as seen by the stimulus generator

    function automatic void emit(logic [2:0] k, int id, logic [31:0] t, logic lst);
        wheel_result_t r;
        r.kind = k;
        r.id   = id[4:0];
        r.tag  = t;
        r.now  = w_now;
        r.last = lst;
        expected_q = {expected_q, r};
    endfunction

    function automatic void list_push(int l, int e);
        w_prev[e] = w_tail[l];
        w_next[e] = LIST_NIL;
        if (w_tail[l] == LIST_NIL)
            w_head[l] = e;
        else
            w_next[w_tail[l]] = e;
        w_tail[l] = e;
        w_place[e] = l;
    endfunction

    function automatic void list_unlink(int l, int e);
        int p;
        int n;
        p = w_prev[e];
        n = w_next[e];
        if (p == LIST_NIL) w_head[l] = n; else w_next[p] = n;
        if (n == LIST_NIL) w_tail[l] = p; else w_prev[n] = p;
    endfunction

    function automatic void release_slot(int e);
        w_deadline[e] = '0;
        w_period[e]   = '0;
        w_tag[e]      = '0;
        w_active[e]   = 1'b0;
        list_push(FREE_LIST, e);
    endfunction

    function automatic logic [63:0] time_left(int e);
        return (w_deadline[e] > w_now) ? w_deadline[e] - w_now : 64'd0;
    endfunction

    function automatic void put_high(int e, logic [63:0] off);
        if (off > BUCKETS - 1) off = BUCKETS - 1;
        list_push(BUCKETS + (w_hcur + int'(off)) % BUCKETS, e);
    endfunction

    function automatic void arm_slot(int e, bit rearm);
        logic [63:0] d;
        d = time_left(e);
        if (d < BUCKETS)
        begin
            if (d == 0) d = 1;
            list_push((w_lcur + int'(d)) % BUCKETS, e);
        end
        else if (d < FAR)
        begin
            put_high(e, d / BUCKETS - 1);
        end
        else if (rearm)
        begin
            put_high(e, BUCKETS - 1);
        end
        else
        begin
            // far deadline: fires right away
            emit(K_FIRED, e, w_tag[e], 1'b0);
            if (w_period[e] > 0)
            begin
                w_deadline[e] = w_now + w_period[e];
                arm_slot(e, 1'b1);
            end
            else
            begin
                release_slot(e);
            end
        end
    endfunction

    function automatic void fire(int e);
        emit(K_FIRED, e, w_tag[e], 1'b0);
        if (w_period[e] > 0)
        begin
            w_deadline[e] = w_now + w_period[e];
            arm_slot(e, 1'b1);
        end
        else
        begin
            release_slot(e);
        end
    endfunction

    function automatic void advance_tick();
        int e;
        int nx;
        logic [63:0] rem;
        w_now = w_now + 1;
        e = w_head[w_lcur];
        w_head[w_lcur] = LIST_NIL;
        w_tail[w_lcur] = LIST_NIL;
        while (e != LIST_NIL)
        begin
            nx = w_next[e];
            fire(e);
            e = nx;
        end
        w_lcur++;
        if (w_lcur >= BUCKETS)
        begin
            // level 0 wrapped: cascade one level-1 bucket
            w_lcur = 0;
            e = w_head[BUCKETS + w_hcur];
            w_head[BUCKETS + w_hcur] = LIST_NIL;
            w_tail[BUCKETS + w_hcur] = LIST_NIL;
            w_hcur = (w_hcur + 1) % BUCKETS;
            while (e != LIST_NIL)
            begin
                nx = w_next[e];
                rem = time_left(e);
                if (rem == 0)
                    fire(e);
                else if (rem < BUCKETS)
                    list_push((w_lcur + int'(rem)) % BUCKETS, e);
                else
                    put_high(e, rem / BUCKETS - 1);
                e = nx;
            end
        end
    endfunction

    function automatic void wheel_reset();
        w_now  = '0;
        w_lcur = 0;
        w_hcur = 0;
        for (int i = 0; i <= 2 * BUCKETS; i++)
        begin
            w_head[i] = LIST_NIL;
            w_tail[i] = LIST_NIL;
        end
        for (int i = 0; i < TIMERS; i++) release_slot(i);
    endfunction

    // Works out every result one accepted command causes.
    function automatic void predict_command(cmd_item_t c);
        int e;
        logic [31:0] t;
        if (c.cmd == CMD_TICK)
        begin
            advance_tick();
            emit(K_TICK_DONE, 0, '0, 1'b1);
        end
        else if (c.cmd == CMD_CANCEL)
        begin
            if (c.hnd < TIMERS && w_active[c.hnd])
            begin
                e = c.hnd;
                t = w_tag[e];
                if (w_place[e] < 2 * BUCKETS) list_unlink(w_place[e], e);
                release_slot(e);
                emit(K_CANCELLED, e, t, 1'b1);
            end
            else
            begin
                emit(K_FREE, c.hnd, '0, 1'b1);
            end
        end
        else
        begin
            e = w_head[FREE_LIST];
            if (e == LIST_NIL || (c.cmd == CMD_PERIODIC && c.per == 0))
            begin
                emit(K_REFUSED, 0, c.tag, 1'b1);
            end
            else
            begin
                list_unlink(FREE_LIST, e);
                w_active[e] = 1'b1;
                w_tag[e]    = c.tag;
                if (c.cmd == CMD_ONESHOT)
                begin
                    w_deadline[e] = c.dl;
                    w_period[e]   = '0;
                end
                else
                begin
                    w_deadline[e] = w_now + c.sd;
                    w_period[e]   = c.per;
                end
                arm_slot(e, 1'b0);
                emit(K_CREATED, e, c.tag, 1'b1);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(logic [1:0] c, logic [63:0] dl, logic [63:0] sd,
                             logic [31:0] per, logic [4:0] h, logic [31:0] t);
        cmd_item_t it;
        it.cmd = c; it.dl = dl; it.sd = sd; it.per = per; it.hnd = h; it.tag = t;
        if (c == CMD_TICK) sched_now++;
        cmd_q = {cmd_q, it};
    endtask

    function automatic logic [63:0] rand_offset();
        case ($urandom_range(0, 9))
            0:       return {$urandom, $urandom};
            1:       return 64'd0;
            2, 3, 4: return $urandom_range(1, 70);
            5, 6, 7: return $urandom_range(64, 3000);
            8:       return FAR - 2 + $urandom_range(0, 4);
            default: return $urandom_range(100, 400);
        endcase
    endfunction

    function automatic logic [31:0] rand_period();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return FAR + $urandom_range(0, 500);
            default: return $urandom_range(1, 150);
        endcase
    endfunction

    task automatic queue_random();
        logic [63:0] dl;
        int r;
        r = $urandom_range(0, 99);
        if (r < 48)
        begin
            queue_cmd(CMD_TICK, {$urandom, $urandom}, {$urandom, $urandom},
                      $urandom, 5'($urandom), $urandom);
        end
        else if (r < 68)
        begin
            if ($urandom_range(0, 7) == 0)
                dl = (sched_now > 5) ? sched_now - $urandom_range(0, 5) : 64'd0;
            else
                dl = sched_now + rand_offset();
            queue_cmd(CMD_ONESHOT, dl, {$urandom, $urandom}, $urandom,
                      5'($urandom), $urandom);
        end
        else if (r < 84)
        begin
            queue_cmd(CMD_PERIODIC, {$urandom, $urandom}, rand_offset(),
                      rand_period(), 5'($urandom), $urandom);
        end
        else
        begin
            queue_cmd(CMD_CANCEL, {$urandom, $urandom}, {$urandom, $urandom},
                      $urandom, 5'($urandom_range(0, 31)), $urandom);
        end
    endtask

    // sender stops until the wheel has answered everything
    task automatic drain();
        wait (cmd_q.size() == 0 && !in_valid && expected_q.size() == 0);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: one command transfer at a time, random gap before each
    // ------------------------------------------------------------------
    initial
    begin
        in_valid      = 1'b0;
        cmd           = CMD_TICK;
        deadline_tick = '0;
        start_delay   = '0;
        period        = '0;
        handle        = '0;
        user_tag      = '0;
        sent_cnt      = 0;
        gap           = 0;
        quiet         = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || acc_cnt == sent_cnt))
        begin
            if (gap > 0)
            begin
                gap <= gap - 1;
                in_valid <= 1'b0;
            end
            else if (cmd_q.size() > 0)
            begin
                cmd_item_t it;
                it = cmd_q[0];
                cmd_q.delete(0);
                cmd           <= it.cmd;
                deadline_tick <= it.dl;
                start_delay   <= it.sd;
                period        <= it.per;
                handle        <= it.hnd;
                user_tag      <= it.tag;
                in_valid      <= 1'b1;
                sent_cnt      <= sent_cnt + 1;
                if ($urandom_range(0, 19) == 0) quiet = ~quiet;
                gap <= quiet ? 0 : $urandom_range(0, 4);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: per-result random stall, plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        rx_seen   = 0;
        rx_wait   = 0;
        hold_cnt  = 0;
        hold_done = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_cnt  = 400;
        end
        if (rx_seen != res_cnt)
        begin
            rx_seen = res_cnt;
            rx_wait = quiet ? 0 : $urandom_range(0, 4);
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on command transfer, check on result transfer
    // ------------------------------------------------------------------
    initial
    begin
        acc_cnt     = 0;
        res_cnt     = 0;
        fails       = 0;
        idle_cycles = 0;
        wheel_reset();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (in_valid && in_ready)
            begin
                cmd_item_t c;
                c.cmd = cmd; c.dl = deadline_tick; c.sd = start_delay;
                c.per = period; c.hnd = handle; c.tag = user_tag;
                predict_command(c);
                acc_cnt++;
                idle_cycles = 0;
            end
            if (out_valid && out_ready)
            begin
                wheel_result_t x;
                idle_cycles = 0;
                res_cnt++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d id=%0d tag=%h now=%0d last=%0b",
                             $time, kind, timer_id, fired_tag, now_tick, last);
                    fails++;
                end
                else
                begin
                    x = expected_q[0];
                    expected_q.delete(0);
                    if (kind !== x.kind || timer_id !== x.id || fired_tag !== x.tag ||
                        now_tick !== x.now || last !== x.last)
                    begin
                        $display("%0t: mismatch exp kind=%0d id=%0d tag=%h now=%0d last=%0b",
                                 $time, x.kind, x.id, x.tag, x.now, x.last);
                        $display("%0t:          got kind=%0d id=%0d tag=%h now=%0d last=%0b",
                                 $time, kind, timer_id, fired_tag, now_tick, last);
                        fails++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("%0t: watchdog expired", $time);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        hold_req  = 1'b0;
        sched_now = '0;
        wait (rst_n);
        @(negedge clk);

        // directed: far one-shot fires at once, past deadline, zero period,
        // far periodic with small and with far re-arm, cancels, late-by-one
        queue_cmd(CMD_ONESHOT, '1, '0, '0, '0, 32'hFFFF_FFFF);
        queue_cmd(CMD_ONESHOT, 64'd0, '1, '1, '1, 32'h0000_0001);
        queue_cmd(CMD_PERIODIC, '0, 64'd5, 32'd0, '0, 32'hA5A5_5A5A);
        queue_cmd(CMD_PERIODIC, '0, '1, 32'd3, '0, 32'h1234_5678);
        queue_cmd(CMD_PERIODIC, '0, '1, '1, '0, 32'h8765_4321);
        queue_cmd(CMD_ONESHOT, 64'd63, '0, '0, '0, 32'h0000_0063);
        queue_cmd(CMD_ONESHOT, 64'd64, '0, '0, '0, 32'h0000_0064);
        queue_cmd(CMD_ONESHOT, FAR - 1, '0, '0, '0, 32'h0000_0FFF);
        queue_cmd(CMD_ONESHOT, FAR, '0, '0, '0, 32'h0000_1000);
        queue_cmd(CMD_PERIODIC, '0, 64'd0, 32'd1, '0, 32'h0000_0002);
        queue_cmd(CMD_CANCEL, '0, '0, '0, 5'd31, '0);
        queue_cmd(CMD_CANCEL, '1, '1, '1, 5'd2, '1);
        repeat (5) queue_cmd(CMD_TICK, '0, '0, '0, '0, '0);
        queue_cmd(CMD_CANCEL, '0, '0, '0, 5'd3, '0);
        queue_cmd(CMD_CANCEL, '0, '0, '0, 5'd4, '0);
        queue_cmd(CMD_CANCEL, '0, '0, '0, 5'd1, '0);
        drain();

        repeat (150) queue_random();
        drain();

        // long receiver hold while commands keep coming
        hold_req = 1'b1;
        repeat (60) queue_random();
        drain();

        // exhaust the pool, then free every handle
        for (int i = 0; i < TIMERS + 2; i++)
            queue_cmd(CMD_ONESHOT, sched_now + 200 + i * 40, '0, '0, '0, $urandom);
        for (int i = 0; i < TIMERS; i++)
            queue_cmd(CMD_CANCEL, '0, '0, '0, i[4:0], '0);
        drain();

        repeat (170) queue_random();
        drain();

        repeat (60) @(posedge clk);
        if (fails == 0 && expected_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/tltw_pkg.sv
design/two_level_timer_wheel.sv
tb/sv/tb.sv
